FILE: hw/rtl/plan_lane_range_backward_pass_defines.svh
// Assertion macros used by the checker file of the lane range backward pass.
// No dependencies; include by bare file name.
`ifndef PLAN_LANE_RANGE_BACKWARD_PASS_DEFINES_SVH
`define PLAN_LANE_RANGE_BACKWARD_PASS_DEFINES_SVH

// condition implies property in the same cycle
`define PLRBP_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// condition implies property in the next cycle
`define PLRBP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: hw/rtl/plrbp_pkg.sv
// Package for the lane range backward pass: widths, word layouts, sequencer
// states and the divider interface types. No dependencies.
`timescale 1ns / 1ps

package plrbp_pkg;

   localparam int CELL_W  = 12;
   localparam int LANE_W  = 4;
   localparam int DIST_W  = 13;   // running distance, signed
   localparam int TOTAL_W = 14;   // distance sum, signed
   localparam int QUO_W   = 13;   // magnitude of the distance sum
   localparam int FACT_W  = 13;   // lane factor
   localparam int CNT_W   = 6;    // signed lane counts
   localparam int PASS_W  = 5;
   localparam int REQ_W   = 56;
   localparam int RSP_W   = 16;

   localparam int PRIORITY_LEVELS = 3;
   localparam logic [PASS_W-1:0] LANE_PASSES = 5'd16;

   localparam int FOLLOW_RESET_VAL = 70;
   localparam logic [CELL_W-1:0] FOLLOW_RESET = CELL_W'(FOLLOW_RESET_VAL);
   localparam int FACTOR_RESET_VAL = (FOLLOW_RESET_VAL * 2 / PRIORITY_LEVELS < 1) ?
                                     1 : FOLLOW_RESET_VAL * 2 / PRIORITY_LEVELS;
   localparam logic [FACT_W-1:0] FACTOR_RESET = FACT_W'(FACTOR_RESET_VAL);

   // x / PRIORITY_LEVELS for x < 2**13 as (x * RECIP) >> RECIP_SHIFT
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W     = 18;
   localparam int RECIP_VAL   = (2**RECIP_SHIFT + PRIORITY_LEVELS - 1) / PRIORITY_LEVELS;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   localparam logic signed [TOTAL_W-1:0] TOTAL_FLOOR = -14'sd4096;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PREP   = 6'b000010,
      S_DIV    = 6'b000100,
      S_LANE   = 6'b001000,
      S_SHRINK = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // first field in the highest bits
   typedef struct packed {
      logic [LANE_W-1:0] upstream_best_high;
      logic [LANE_W-1:0] upstream_best_low;
      logic [LANE_W-1:0] exit_best_high;
      logic [LANE_W-1:0] exit_best_low;
      logic [LANE_W-1:0] exit_lane_high;
      logic [LANE_W-1:0] exit_lane_low;
      logic [LANE_W-1:0] entry_lane_high;
      logic [LANE_W-1:0] entry_lane_low;
      logic [CELL_W-1:0] start_cell;
      logic [CELL_W-1:0] leg_cells;
   } req_word_type;

   typedef struct packed {
      logic [LANE_W-1:0] new_upstream_high;
      logic [LANE_W-1:0] new_upstream_low;
      logic [LANE_W-1:0] entry_best_high;
      logic [LANE_W-1:0] entry_best_low;
   } rsp_word_type;

   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [FACT_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;

endpackage

FILE: hw/rtl/plrbp_divider.sv
// Restoring divider, one quotient bit per cycle, for the lane widening.
// Depends on plrbp_pkg.
`timescale 1ns / 1ps

module plrbp_divider
   import plrbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctl_type  ctl,
   output div_stat_type stat
);

   localparam int STEP_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [FACT_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [FACT_W-1:0] dvs_ff, dvs_in;

   logic [FACT_W:0]   trial;
   logic [FACT_W+1:0] diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUO_W - 1);
         rem_in  = '0;
         quo_in  = ctl.dividend;
         dvs_in  = ctl.divisor;
      end else if (busy_ff) begin
         if (!diff[FACT_W+1]) begin
            rem_in = diff[FACT_W-1:0];
         end else begin
            rem_in = trial[FACT_W-1:0];
         end
         quo_in  = {quo_ff[QUO_W-2:0], ~diff[FACT_W+1]};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

FILE: hw/rtl/plan_lane_range_backward_pass.sv
// Each accepted word passes through the prepare state, the 13-step divider and the lane state,
// then, when the upstream range is updated, up to 16 lane shrink passes.
// A new word is taken only in the idle state, after the previous word has finished;
// a finished result may wait in the output register while the next word is taken.
// Reset: synchronous, active high; clears distance, override and valid; sets follow distance (70).
`timescale 1ns / 1ps

module plan_lane_range_backward_pass
   import plrbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // leg_cells, start_cell, entry_lane_low, entry_lane_high, exit_lane_low,
   // exit_lane_high, exit_best_low, exit_best_high, upstream_best_low, upstream_best_high
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tuser,   // plan_start
   input  logic             req_tlast,   // plan_finish
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // entry_best_low, entry_best_high, new_upstream_low, new_upstream_high
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tuser,   // upstream_written
   input  logic             csr_wr_en,
   input  logic [CELL_W-1:0] csr_wr_data
);

   state_type state_ff, state_in;
   req_word_type item_ff, item_in;
   logic pstart_ff, pstart_in, pfinish_ff, pfinish_in;
   logic [CELL_W-1:0] follow_ff, follow_in;
   logic [FACT_W-1:0] factor_ff, factor_in;
   logic signed [DIST_W-1:0] run_ff, run_in;
   logic ovr_valid_ff, ovr_valid_in;
   logic [LANE_W-1:0] ovr_low_ff, ovr_low_in, ovr_high_ff, ovr_high_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic within_ff, within_in, sign_ff, sign_in;
   logic [LANE_W-1:0] xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [LANE_W-1:0] bl_ff, bl_in, bh_ff, bh_in;
   logic [LANE_W-1:0] in_lo_ff, in_lo_in, in_hi_ff, in_hi_in;
   logic [LANE_W-1:0] out_lo_ff, out_lo_in, out_hi_ff, out_hi_in;
   logic signed [CNT_W-1:0] in_n_ff, in_n_in, out_n_ff, out_n_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic written_ff, written_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic rsp_flag_ff, rsp_flag_in;

   div_ctl_type  div_ctl;
   div_stat_type div_stat;

   // lane factor from a configuration write
   logic [CELL_W+RECIP_W:0] cfg_prod;
   logic [FACT_W-1:0]       cfg_factor;

   // distance step
   logic signed [TOTAL_W-1:0] prep_run, prep_cells, prep_sum, prep_total, prep_follow;
   logic                      prep_over, prep_within;
   logic [LANE_W-1:0]         prep_xlo, prep_xhi;
   logic [QUO_W-1:0]          prep_mag;

   // lane narrowing
   logic signed [15:0] lanes, bl_cand, bh_cand, lane_in_lo, lane_in_hi, lane_bl;
   logic [LANE_W-1:0]  lane_bl_new, lane_bh_new;

   // one shrink pass
   logic                    sh_run, sh_moved, sh_brk;
   logic [LANE_W-1:0]       sh_in_lo, sh_in_hi, sh_out_lo, sh_out_hi;
   logic signed [CNT_W-1:0] sh_out_n;

   plrbp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   always_comb begin
      cfg_prod   = {csr_wr_data, 1'b0} * RECIP;
      cfg_factor = cfg_prod[RECIP_SHIFT +: FACT_W];
      if (cfg_factor == '0) begin
         cfg_factor = FACT_W'(1);
      end
   end

   always_comb begin
      prep_run    = pstart_ff ? '0 : TOTAL_W'(run_ff);
      prep_follow = $signed({2'b00, follow_ff});
      if (pfinish_ff) begin
         prep_cells = $signed({2'b00, item_ff.leg_cells}) - $signed({2'b00, item_ff.start_cell});
      end else begin
         prep_cells = $signed({2'b00, item_ff.leg_cells});
      end
      prep_sum = prep_run + prep_cells;
      if (ovr_valid_ff && !pstart_ff) begin
         prep_xlo = ovr_low_ff;
         prep_xhi = ovr_high_ff;
      end else begin
         prep_xlo = item_ff.exit_best_low;
         prep_xhi = item_ff.exit_best_high;
      end
      prep_over  = prep_sum > prep_follow;
      prep_total = prep_sum;
      // beyond the look-ahead: restart from this leg, use the full exit range
      if (prep_over) begin
         prep_total = prep_cells;
         prep_xlo   = item_ff.exit_lane_low;
         prep_xhi   = item_ff.exit_lane_high;
      end
      prep_within = prep_total <= prep_follow;
      prep_mag    = prep_total[TOTAL_W-1] ? QUO_W'(-prep_total) : QUO_W'(prep_total);
   end

   always_comb begin
      lanes = $signed({3'b000, div_stat.quotient});
      if (sign_ff) begin
         lanes = -lanes;
      end
      bl_cand    = $signed({12'd0, xlo_ff}) - lanes;
      bh_cand    = $signed({12'd0, xhi_ff}) + lanes;
      lane_in_lo = $signed({12'd0, item_ff.entry_lane_low});
      lane_in_hi = $signed({12'd0, item_ff.entry_lane_high});
      lane_bl    = lane_in_lo;
      if (lane_in_lo < bl_cand) begin
         lane_bl = (lane_in_hi < bl_cand) ? lane_in_hi : bl_cand;
      end
      lane_bl_new = lane_bl[LANE_W-1:0];
      lane_bh_new = item_ff.entry_lane_high;
      if (lane_in_hi > bh_cand) begin
         lane_bh_new = (lane_bl > bh_cand) ? lane_bl[LANE_W-1:0] : bh_cand[LANE_W-1:0];
      end
      if (!within_ff) begin
         lane_bl_new = item_ff.entry_lane_low;
         lane_bh_new = item_ff.entry_lane_high;
      end
   end

   always_comb begin
      sh_run    = (pass_ff < LANE_PASSES) && (out_n_ff > in_n_ff);
      sh_moved  = 1'b0;
      sh_in_lo  = in_lo_ff;
      sh_in_hi  = in_hi_ff;
      sh_out_lo = out_lo_ff;
      sh_out_hi = out_hi_ff;
      sh_out_n  = out_n_ff;
      if (bl_ff > sh_in_lo) begin
         sh_in_lo  = sh_in_lo + LANE_W'(1);
         sh_out_lo = sh_out_lo + LANE_W'(1);
         sh_out_n  = sh_out_n - CNT_W'(1);
         sh_moved  = 1'b1;
      end
      if (sh_out_n > in_n_ff && bh_ff < sh_in_hi) begin
         sh_in_hi  = sh_in_hi - LANE_W'(1);
         sh_out_hi = sh_out_hi - LANE_W'(1);
         sh_out_n  = sh_out_n - CNT_W'(1);
         sh_moved  = 1'b1;
      end
      sh_brk = (bl_ff == sh_in_lo && bh_ff == sh_in_hi) || !sh_moved;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      pstart_in    = pstart_ff;
      pfinish_in   = pfinish_ff;
      follow_in    = follow_ff;
      factor_in    = factor_ff;
      run_in       = run_ff;
      ovr_valid_in = ovr_valid_ff;
      ovr_low_in   = ovr_low_ff;
      ovr_high_in  = ovr_high_ff;
      total_in     = total_ff;
      within_in    = within_ff;
      sign_in      = sign_ff;
      xlo_in       = xlo_ff;
      xhi_in       = xhi_ff;
      bl_in        = bl_ff;
      bh_in        = bh_ff;
      in_lo_in     = in_lo_ff;
      in_hi_in     = in_hi_ff;
      out_lo_in    = out_lo_ff;
      out_hi_in    = out_hi_ff;
      in_n_in      = in_n_ff;
      out_n_in     = out_n_ff;
      pass_in      = pass_ff;
      written_in   = written_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_flag_in  = rsp_flag_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = prep_mag;
      div_ctl.divisor  = factor_ff;

      if (csr_wr_en) begin
         follow_in = csr_wr_data;
         factor_in = cfg_factor;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in    = req_tdata;
               pstart_in  = req_tuser;
               pfinish_in = req_tlast;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            total_in      = prep_total;
            within_in     = prep_within;
            sign_in       = prep_total[TOTAL_W-1];
            xlo_in        = prep_xlo;
            xhi_in        = prep_xhi;
            div_ctl.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_LANE;
            end
         end
         S_LANE: begin
            bl_in      = lane_bl_new;
            bh_in      = lane_bh_new;
            in_lo_in   = item_ff.entry_lane_low;
            in_hi_in   = item_ff.entry_lane_high;
            out_lo_in  = item_ff.upstream_best_low;
            out_hi_in  = item_ff.upstream_best_high;
            in_n_in    = $signed({2'b00, lane_bh_new}) - $signed({2'b00, lane_bl_new})
                         + CNT_W'(1);
            out_n_in   = $signed({2'b00, item_ff.upstream_best_high})
                         - $signed({2'b00, item_ff.upstream_best_low}) + CNT_W'(1);
            pass_in    = '0;
            written_in = within_ff && !pfinish_ff;
            state_in   = (within_ff && !pfinish_ff) ? S_SHRINK : S_FINISH;
         end
         S_SHRINK: begin
            if (!sh_run) begin
               state_in = S_FINISH;
            end else begin
               in_lo_in  = sh_in_lo;
               in_hi_in  = sh_in_hi;
               out_lo_in = sh_out_lo;
               out_hi_in = sh_out_hi;
               out_n_in  = sh_out_n;
               pass_in   = pass_ff + PASS_W'(1);
               if (sh_brk) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in                  = 1'b1;
               rsp_word_in.entry_best_low    = bl_ff;
               rsp_word_in.entry_best_high   = bh_ff;
               rsp_word_in.new_upstream_low  = written_ff ? out_lo_ff : '0;
               rsp_word_in.new_upstream_high = written_ff ? out_hi_ff : '0;
               rsp_flag_in                   = written_ff;
               run_in       = (total_ff < TOTAL_FLOOR) ? DIST_W'(TOTAL_FLOOR) : DIST_W'(total_ff);
               ovr_valid_in = written_ff;
               ovr_low_in   = written_ff ? out_lo_ff : '0;
               ovr_high_in  = written_ff ? out_hi_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         follow_ff    <= FOLLOW_RESET;
         factor_ff    <= FACTOR_RESET;
         run_ff       <= '0;
         ovr_valid_ff <= 1'b0;
         ovr_low_ff   <= '0;
         ovr_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         follow_ff    <= follow_in;
         factor_ff    <= factor_in;
         run_ff       <= run_in;
         ovr_valid_ff <= ovr_valid_in;
         ovr_low_ff   <= ovr_low_in;
         ovr_high_ff  <= ovr_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pstart_ff   <= pstart_in;
      pfinish_ff  <= pfinish_in;
      total_ff    <= total_in;
      within_ff   <= within_in;
      sign_ff     <= sign_in;
      xlo_ff      <= xlo_in;
      xhi_ff      <= xhi_in;
      bl_ff       <= bl_in;
      bh_ff       <= bh_in;
      in_lo_ff    <= in_lo_in;
      in_hi_ff    <= in_hi_in;
      out_lo_ff   <= out_lo_in;
      out_hi_ff   <= out_hi_in;
      in_n_ff     <= in_n_in;
      out_n_ff    <= out_n_in;
      pass_ff     <= pass_in;
      written_ff  <= written_in;
      rsp_word_ff <= rsp_word_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_flag_ff;

endmodule

FILE: hw/rtl/plrbp_checker.sv
// Port-level checks for the lane range backward pass, bound to the top level.
// Depends on plrbp_pkg and plan_lane_range_backward_pass_defines.svh.
`timescale 1ns / 1ps
`include "plan_lane_range_backward_pass_defines.svh"

module plrbp_checker
   import plrbp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_W-1:0]  req_tdata,
   input logic              req_tuser,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata,
   input logic              rsp_tuser,
   input logic              csr_wr_en,
   input logic [CELL_W-1:0] csr_wr_data
);

   `PLRBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")

   `PLRBP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      !req_tready, "new word taken while the previous one is in work")

   `PLRBP_ASSERT_NOW(a_upstream_zero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[15:8] == 8'd0, "upstream lanes nonzero without upstream update")

   `PLRBP_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset,
      !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind plan_lane_range_backward_pass plrbp_checker u_checker (.*);

FILE: test/plan_lane_range_backward_pass_tb.sv
// Self-checking bench for plan_lane_range_backward_pass: directed legs, then random plans
// under several follow distances and idle patterns, checked by an in-bench lane predictor.
// Depends on plrbp_pkg and the plan_lane_range_backward_pass RTL.
`timescale 1ns / 1ps

module plan_lane_range_backward_pass_tb;
   import plrbp_pkg::*;

   localparam int LANE_PRIORITIES = 3;
   localparam int SHRINK_PASS_MAX = 16;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_CYCLES     = 400;
   localparam int PHASE_LEGS      = 225;
   localparam int DIRECTED_ROWS   = 18;

   typedef struct packed {
      logic [CELL_W-1:0] cells;
      logic [CELL_W-1:0] start;
      logic              pstart;
      logic              pfinish;
      logic [LANE_W-1:0] en_lo;
      logic [LANE_W-1:0] en_hi;
      logic [LANE_W-1:0] ex_lo;
      logic [LANE_W-1:0] ex_hi;
      logic [LANE_W-1:0] xb_lo;
      logic [LANE_W-1:0] xb_hi;
      logic [LANE_W-1:0] up_lo;
      logic [LANE_W-1:0] up_hi;
   } leg_t;

   typedef struct packed {
      logic [LANE_W-1:0] en_lo;
      logic [LANE_W-1:0] en_hi;
      logic [LANE_W-1:0] up_lo;
      logic [LANE_W-1:0] up_hi;
      logic              wr;
   } lane_choice_t;

   typedef struct packed {
      leg_t         leg;
      logic         typed;
      lane_choice_t want;
   } leg_row_t;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_wr_en;
   logic [CELL_W-1:0] csr_wr_data;

   // predictor state
   logic [CELL_W-1:0] follow_cfg;
   int                run_dist;
   bit                ovr_valid;
   int                ovr_lo, ovr_hi;

   lane_choice_t lane_choices_q[$];

   int unsigned legs_sent, plans_sent, results_seen, upstream_updates;
   int unsigned bad_words, settings_used, cycles;
   int          tx_idle_pct, rx_idle_pct, phase_no;

   // legs (cells, start, pstart, pfinish, entry lo/hi, exit lo/hi, exit best lo/hi,
   // upstream best lo/hi), typed flag, expected lanes (entry lo/hi, upstream lo/hi, written)
   leg_row_t directed_legs [DIRECTED_ROWS] = '{
      '{'{0, 0, 1, 1, 0, 15, 0, 15, 5, 9, 0, 0}, 1, '{5, 9, 0, 0, 0}},
      '{'{4095, 4095, 1, 0, 3, 12, 1, 14, 6, 6, 15, 15}, 1, '{3, 12, 0, 0, 0}},
      // start cell beyond the leg: negative distance, widening goes the other way
      '{'{0, 4095, 1, 1, 2, 10, 0, 15, 4, 6, 0, 0}, 1, '{10, 10, 0, 0, 0}},
      '{'{0, 4095, 0, 1, 0, 15, 0, 15, 0, 15, 0, 15}, 0, '0},
      '{'{10, 0, 1, 0, 0, 7, 0, 7, 2, 3, 0, 9}, 0, '0},
      '{'{20, 0, 0, 0, 1, 6, 0, 9, 9, 9, 3, 8}, 0, '0},
      '{'{30, 0, 0, 0, 0, 15, 2, 13, 4, 4, 0, 15}, 0, '0},
      '{'{25, 5, 0, 1, 4, 11, 3, 12, 6, 7, 0, 15}, 0, '0},
      '{'{0, 0, 1, 0, 12, 3, 9, 2, 15, 0, 14, 1}, 0, '0},
      '{'{70, 0, 0, 0, 0, 15, 0, 15, 7, 8, 15, 0}, 0, '0},
      '{'{1, 0, 0, 0, 0, 15, 5, 6, 3, 3, 2, 12}, 0, '0},
      '{'{5, 0, 0, 0, 5, 5, 1, 9, 0, 15, 4, 11}, 0, '0},
      '{'{4095, 0, 1, 1, 7, 8, 0, 15, 0, 0, 0, 0}, 1, '{7, 8, 0, 0, 0}},
      '{'{0, 4095, 0, 0, 15, 15, 15, 15, 15, 15, 15, 15}, 0, '0},
      '{'{4095, 4095, 1, 1, 15, 15, 15, 15, 15, 15, 15, 15}, 1, '{15, 15, 0, 0, 0}},
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 1}},
      '{'{12, 0, 0, 0, 0, 15, 0, 15, 0, 0, 0, 15}, 0, '0},
      '{'{3, 1, 0, 1, 2, 9, 0, 15, 4, 5, 6, 10}, 0, '0}
   };

   plan_lane_range_backward_pass DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Lane choice for one leg; advances the running distance and the override.
   function automatic lane_choice_t plan_leg_lanes(leg_t leg);
      int cells, factor, follow, total, lanes, near;
      int lo, hi, in_lo, in_hi, out_lo, out_hi, in_n, out_n, xb_lo, xb_hi;
      bit moved, wrote;
      lane_choice_t res;
      follow = follow_cfg;
      factor = follow * 2 / LANE_PRIORITIES;
      if (factor < 1) factor = 1;
      cells = leg.cells;
      xb_lo = leg.xb_lo;
      xb_hi = leg.xb_hi;
      if (leg.pstart) begin
         run_dist = 0;
         ovr_valid = 0;
      end
      if (ovr_valid) begin
         xb_lo = ovr_lo;
         xb_hi = ovr_hi;
      end
      if (leg.pfinish) cells = cells - int'(leg.start);
      lo = leg.en_lo;
      hi = leg.en_hi;
      in_lo = lo;
      in_hi = hi;
      out_lo = leg.up_lo;
      out_hi = leg.up_hi;
      total = run_dist + cells;
      // past the look-ahead: restart from this leg, full exit range
      if (total > follow) begin
         total = cells;
         xb_lo = leg.ex_lo;
         xb_hi = leg.ex_hi;
      end
      if (total <= follow) begin
         lanes = total / factor;
         near = xb_lo - lanes;
         if (lo < near) lo = (hi < near) ? hi : near;
         near = xb_hi + lanes;
         if (hi > near) hi = (lo > near) ? lo : near;
      end
      wrote = 0;
      if (total <= follow && !leg.pfinish) begin
         if (lo > in_lo || hi < in_hi) begin
            in_n = hi - lo + 1;
            out_n = out_hi - out_lo + 1;
            for (int pass = 0; pass < SHRINK_PASS_MAX && out_n > in_n; pass++) begin
               moved = 0;
               if (lo > in_lo) begin
                  in_lo++;
                  out_lo++;
                  out_n--;
                  moved = 1;
               end
               if (out_n > in_n && hi < in_hi) begin
                  in_hi--;
                  out_hi--;
                  out_n--;
                  moved = 1;
               end
               if (lo == in_lo && hi == in_hi) break;
               if (!moved) break;
            end
         end
         wrote = 1;
      end
      if (total < -4096) total = -4096;
      run_dist = total;
      ovr_valid = wrote;
      ovr_lo = wrote ? (out_lo & 15) : 0;
      ovr_hi = wrote ? (out_hi & 15) : 0;
      res.en_lo = lo[3:0];
      res.en_hi = hi[3:0];
      res.up_lo = ovr_lo[3:0];
      res.up_hi = ovr_hi[3:0];
      res.wr = wrote;
      return res;
   endfunction

   // mostly an ordered lane range, sometimes inverted; returns {hi, lo}
   function automatic logic [7:0] lane_pair();
      logic [3:0] a, b;
      a = $urandom;
      b = $urandom;
      if ($urandom_range(0, 99) < 80 && a > b) return {a, b};
      return {b, a};
   endfunction

   function automatic leg_t random_leg();
      leg_t leg;
      int unsigned roll, reach;
      reach = follow_cfg;
      roll = $urandom_range(0, 99);
      // mostly short legs so that plans stay within the look-ahead for a while
      if (roll < 70) leg.cells = $urandom_range(0, reach / 3 + 3);
      else if (roll < 90) leg.cells = $urandom_range(0, (reach + 10 > 4095) ? 4095 : reach + 10);
      else leg.cells = $urandom;
      leg.start = ($urandom_range(0, 99) < 70) ? $urandom_range(0, leg.cells) : $urandom;
      leg.pstart = 1'b0;
      leg.pfinish = 1'b0;
      {leg.en_hi, leg.en_lo} = lane_pair();
      {leg.ex_hi, leg.ex_lo} = lane_pair();
      {leg.xb_hi, leg.xb_lo} = lane_pair();
      {leg.up_hi, leg.up_lo} = lane_pair();
      return leg;
   endfunction

   task automatic send_leg(input leg_t leg, input bit typed, input lane_choice_t want);
      req_word_type word;
      lane_choice_t predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      word.leg_cells = leg.cells;
      word.start_cell = leg.start;
      word.entry_lane_low = leg.en_lo;
      word.entry_lane_high = leg.en_hi;
      word.exit_lane_low = leg.ex_lo;
      word.exit_lane_high = leg.ex_hi;
      word.exit_best_low = leg.xb_lo;
      word.exit_best_high = leg.xb_hi;
      word.upstream_best_low = leg.up_lo;
      word.upstream_best_high = leg.up_hi;
      req_tdata <= word;
      req_tuser <= leg.pstart;
      req_tlast <= leg.pfinish;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = plan_leg_lanes(leg);
      lane_choices_q.push_back(typed ? want : predicted);
      legs_sent++;
      if (leg.pstart) plans_sent++;
   endtask

   task automatic drain_results(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lane_choices_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_follow(input logic [CELL_W-1:0] value);
      drain_results(4);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      follow_cfg = value;
      settings_used++;
   endtask

   // receiver: random stalls, plus one long hold-off early in the first random phase
   initial begin
      int hold_left;
      bit hold_done;
      rsp_tready = 1'b0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (phase_no == 1 && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      lane_choice_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (rsp_tuser) upstream_updates++;
         if (lane_choices_q.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected result word: entry %0d..%0d upstream %0d..%0d written %0b",
                        got.entry_best_low, got.entry_best_high, got.new_upstream_low,
                        got.new_upstream_high, rsp_tuser);
         end else begin
            want = lane_choices_q.pop_front();
            if (got.entry_best_low !== want.en_lo || got.entry_best_high !== want.en_hi ||
                got.new_upstream_low !== want.up_lo || got.new_upstream_high !== want.up_hi ||
                rsp_tuser !== want.wr) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("result %0d mismatch: exp entry %0d..%0d up %0d..%0d wr %0b, got entry %0d..%0d up %0d..%0d wr %0b",
                           results_seen, want.en_lo, want.en_hi, want.up_lo, want.up_hi, want.wr,
                           got.entry_best_low, got.entry_best_high, got.new_upstream_low,
                           got.new_upstream_high, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", lane_choices_q.size());
         $display("FAIL plan_lane_range_backward_pass");
         $finish;
      end
   end

   initial begin
      logic [CELL_W-1:0] follow_list [6];
      leg_t leg;
      int unsigned quota, roll, legs_in_plan;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      follow_cfg = 70;
      run_dist = 0;
      ovr_valid = 0;
      ovr_lo = 0;
      ovr_hi = 0;
      legs_sent = 0;
      plans_sent = 0;
      results_seen = 0;
      upstream_updates = 0;
      bad_words = 0;
      settings_used = 0;
      cycles = 0;
      phase_no = 0;
      tx_idle_pct = 12;
      rx_idle_pct = 75;
      follow_list = '{$urandom_range(20, 400), 0, 4095, 1, $urandom_range(0, 4095), 70};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed legs run at the reset follow distance
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_leg(directed_legs[i].leg, directed_legs[i].typed, directed_legs[i].want);

      for (int ph = 1; ph <= 6; ph++) begin
         set_follow(follow_list[ph-1]);
         case ((ph - 1) % 3)
            0: begin tx_idle_pct = 12; rx_idle_pct = 75; end
            1: begin tx_idle_pct = 75; rx_idle_pct = 12; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         phase_no = ph;
         quota = legs_sent + PHASE_LEGS;
         while (legs_sent < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               // noise: any bits at all
               leg = random_leg();
               leg.cells = $urandom;
               leg.start = $urandom;
               leg.pstart = $urandom;
               leg.pfinish = $urandom;
               send_leg(leg, 1'b0, '0);
            end else begin
               legs_in_plan = $urandom_range(1, 8);
               for (int k = 0; k < legs_in_plan; k++) begin
                  leg = random_leg();
                  // a few plans lose their start marker
                  leg.pstart = (k == 0) && (roll >= 20);
                  leg.pfinish = (k == legs_in_plan - 1);
                  send_leg(leg, 1'b0, '0);
               end
            end
         end
      end

      drain_results(40);
      $display("%0d legs (%0d marked plans) over %0d follow settings, %0d results checked",
               legs_sent, plans_sent, settings_used + 1, results_seen);
      $display("%0d results updated the upstream range, %0d bad words", upstream_updates,
               bad_words);
      if (bad_words == 0 && lane_choices_q.size() == 0)
         $display("PASS plan_lane_range_backward_pass");
      else
         $display("FAIL plan_lane_range_backward_pass");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/plrbp_pkg.sv
hw/rtl/plrbp_divider.sv
hw/rtl/plan_lane_range_backward_pass.sv
hw/rtl/plrbp_checker.sv
test/plan_lane_range_backward_pass_tb.sv
